### hdl/tmtw_pkg.sv
// shared constants and types of the text mode terminal writer
`timescale 1ns / 1ps

package tmtw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 4;

  // field widths
  localparam int RowW   = 5;
  localparam int ColW   = 7;
  localparam int AddrW  = 11;
  localparam int WordW  = 16;
  localparam int CountW = 3;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // one decoded input word: cell writes to emit and the cursor it leaves
  typedef struct packed {
    logic              wr;
    logic [AddrW-1:0]  addr;
    logic [WordW-1:0]  word;
    logic [AddrW-1:0]  cursor;
    logic [CountW-1:0] last_idx;
  } item_t;

endpackage

### hdl/tmtw_stream_if.sv
// valid/ready channel interfaces for character input and cell output
`timescale 1ns / 1ps

interface tmtw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [7:0] attribute;

  modport source (output valid, char_code, attribute, input ready);
  modport sink   (input valid, char_code, attribute, output ready);
endinterface

interface tmtw_cell_if;
  logic        valid;
  logic        ready;
  logic        cell_write;
  logic [10:0] cell_address;
  logic [15:0] cell_word;
  logic [10:0] cursor_position;
  logic        last;

  modport source (output valid, cell_write, cell_address, cell_word, cursor_position, last,
                  input ready);
  modport sink   (input valid, cell_write, cell_address, cell_word, cursor_position, last,
                  output ready);
endinterface

### hdl/text_mode_terminal_writer_top.sv
// Text mode terminal writer: character stream in, text cell writes out.
//
// char_in takes one word per cycle while ready: a character byte and an attribute byte.
// cell_out gives the results of each word: a cell write if any (address, word with
// the attribute in the high byte) and, on the word flagged last, the linear
// cursor position after the character.
// Newline, printable characters and backspace give one result each. A tab
// gives one result per space, up to TAB_WIDTH, one per cycle unless cell_out stalls.
// An accepted word passes through the item register and then the output
// register before it appears on cell_out.
// Throughput: one input word per cycle for single-result characters unless
// cell_out stalls; a tab holds char_in.ready low until its last result moves
// on. The rate is set by the single item register feeding the output register.
// Reset puts the cursor at row 0, column 0, empties both registers and holds
// char_in.ready low.
// When the receiver stalls, the output register holds its word; one more
// input word is still taken into the item register if it is empty; after that
// char_in.ready drops until cell_out drains.
`timescale 1ns / 1ps

module text_mode_terminal_writer_top #(
  parameter int COLUMNS   = tmtw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tmtw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tmtw_pkg::TAB_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tmtw_char_if.sink   char_in,
  tmtw_cell_if.source cell_out
);
  import tmtw_pkg::*;

  item_t item;
  logic  ready;
  logic  accept;

  // input handshake
  assign char_in.ready = ready;
  assign accept        = char_in.valid && ready;

  tmtw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_in.char_code),
    .attribute (char_in.attribute),
    .item      (item)
  );

  tmtw_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item_in  (item),
    .ready    (ready),
    .cell_out (cell_out)
  );

endmodule

### hdl/tmtw_cursor.sv
// cursor registers and character decode into one pending item
`timescale 1ns / 1ps

module tmtw_cursor #(
  parameter int COLUMNS   = tmtw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tmtw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tmtw_pkg::TAB_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      char_code,
  input  logic [7:0]      attribute,
  output tmtw_pkg::item_t item
);
  import tmtw_pkg::*;

  localparam logic [ColW:0] Cols = (ColW + 1)'(COLUMNS);

  logic [RowW-1:0] cursor_row;
  logic [ColW-1:0] cursor_column;
  logic [RowW-1:0] cursor_row_next;
  logic [ColW-1:0] cursor_column_next;

  logic [RowW:0]   row_p1;
  logic [RowW-1:0] row_wrap;
  logic [RowW-1:0] row_prev;
  logic [ColW:0]   col_p1;
  logic [ColW:0]   col_tab;
  logic [ColW-1:0] write_col;

  // row * COLUMNS + column, kept to the address width
  function automatic logic [AddrW-1:0] linear_index(input logic [RowW-1:0] r,
                                                    input logic [ColW-1:0] c);
    logic [RowW+ColW:0] prod;
    prod = (RowW + ColW + 1)'(r) * (RowW + ColW + 1)'(COLUMNS);
    return AddrW'(prod + (RowW + ColW + 1)'(c));
  endfunction

  // neighbor rows and columns
  always_comb begin
    row_p1   = {1'b0, cursor_row} + 1'b1;
    row_wrap = (row_p1 >= (RowW + 1)'(ROWS)) ? '0 : row_p1[RowW-1:0];
    row_prev = (cursor_row == '0) ? RowW'(ROWS - 1) : cursor_row - 1'b1;
    col_p1   = {1'b0, cursor_column} + 1'b1;
    col_tab  = {1'b0, cursor_column} + (ColW + 1)'(TAB_WIDTH);
  end

  // decode the character
  always_comb begin
    cursor_row_next    = cursor_row;
    cursor_column_next = cursor_column;
    write_col          = cursor_column;
    item.wr            = 1'b1;
    item.word          = {attribute, CH_SPACE};
    item.last_idx      = '0;
    case (char_code)
      CH_NEWLINE: begin
        item.wr            = 1'b0;
        cursor_column_next = '0;
        cursor_row_next    = row_wrap;
      end
      CH_TAB: begin
        // spaces up to the tab width, never past the row end
        if (col_tab > Cols) begin
          item.last_idx = CountW'(Cols - {1'b0, cursor_column} - 1'b1);
        end else begin
          item.last_idx = CountW'(TAB_WIDTH - 1);
        end
        if (col_tab >= Cols) begin
          cursor_column_next = '0;
          cursor_row_next    = row_wrap;
        end else begin
          cursor_column_next = col_tab[ColW-1:0];
        end
      end
      CH_BACKSPACE: begin
        if (cursor_column == '0) begin
          item.wr            = 1'b0;
          cursor_column_next = ColW'(COLUMNS - 1);
          cursor_row_next    = row_prev;
        end else begin
          cursor_column_next = cursor_column - 1'b1;
          write_col          = cursor_column - 1'b1;
        end
      end
      default: begin
        item.word = {attribute, char_code};
        if (col_p1 >= Cols) begin
          cursor_column_next = '0;
          cursor_row_next    = row_wrap;
        end else begin
          cursor_column_next = col_p1[ColW-1:0];
        end
      end
    endcase
    if (!item.wr) begin
      item.word = '0;
    end
    item.addr   = item.wr ? linear_index(cursor_row, write_col) : '0;
    item.cursor = linear_index(cursor_row_next, cursor_column_next);
  end

  // cursor moves only when a word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row    <= '0;
      cursor_column <= '0;
    end else if (accept) begin
      cursor_row    <= cursor_row_next;
      cursor_column <= cursor_column_next;
    end
  end

endmodule

### hdl/tmtw_sequencer.sv
// item register, tab cell counter and output register
`timescale 1ns / 1ps

module tmtw_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  tmtw_pkg::item_t item_in,
  output logic            ready,
  tmtw_cell_if.source     cell_out
);
  import tmtw_pkg::*;

  item_t             item;
  logic              item_valid;
  logic [CountW-1:0] idx;
  logic              out_valid;
  logic              out_free;
  logic              item_last;

  // output register can load when empty or being drained
  assign out_free  = !out_valid || cell_out.ready;
  assign item_last = (idx == item.last_idx);
  assign ready     = !rst && (!item_valid || (out_free && item_last));

  // pending item and its cell counter
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      idx        <= '0;
    end else if (accept) begin
      item_valid <= 1'b1;
      idx        <= '0;
    end else if (out_free && item_valid) begin
      if (item_last) begin
        item_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && item_valid) begin
      cell_out.cell_write      <= item.wr;
      cell_out.cell_address    <= item.addr + AddrW'(idx);
      cell_out.cell_word       <= item.word;
      cell_out.cursor_position <= item_last ? item.cursor : '0;
      cell_out.last            <= item_last;
    end
  end

  assign cell_out.valid = out_valid;

endmodule

### hdl/tmtw_checker.sv
// port level checks of the terminal writer and their bind
`timescale 1ns / 1ps

module tmtw_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        cell_write,
  input logic [10:0] cell_address,
  input logic [15:0] cell_word,
  input logic [10:0] cursor_position,
  input logic        last
);
  import tmtw_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_address) && $stable(cell_word)
      && $stable(last) && $stable(cell_write))
    else $error("output word changed while stalled");

  // only tab spaces come before the last result
  a_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> cell_write && cursor_position == '0
      && cell_word[7:0] == CH_SPACE)
    else $error("non-last result is not a tab space write");

  // a result without a write is alone and carries no cell
  a_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cell_write |-> last && cell_address == '0 && cell_word == '0)
    else $error("result without write has cell data");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind text_mode_terminal_writer_top tmtw_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (cell_out.valid),
  .out_ready       (cell_out.ready),
  .cell_write      (cell_out.cell_write),
  .cell_address    (cell_out.cell_address),
  .cell_word       (cell_out.cell_word),
  .cursor_position (cell_out.cursor_position),
  .last            (cell_out.last)
);

### sim/tb_text_mode_terminal_writer_top.sv
// self-checking testbench for the text mode terminal writer: cursor, tab and cell write checks
`timescale 1ns / 1ps

module tb_text_mode_terminal_writer_top;
  import tmtw_pkg::*;

  localparam int COLS      = COLUMNS_DEF;
  localparam int ROWS_N    = ROWS_DEF;
  localparam int TAB_W     = TAB_WIDTH_DEF;
  localparam int DIRECTED_N = 22;
  localparam int RANDOM_N   = 408;
  localparam int QUIET_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  // one result word as seen on cell_out
  typedef struct packed {
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] word;
    logic [AddrW-1:0] cursor;
    logic             last;
  } cell_result_t;

  // one stimulus row; typed rows carry their single result written out by hand
  typedef struct packed {
    logic [7:0]   ch;
    logic [7:0]   attr;
    logic         typed;
    cell_result_t exp;
  } char_row_t;

  logic clk = 1'b0;
  logic rst;

  tmtw_char_if char_bus ();
  tmtw_cell_if cell_bus ();

  text_mode_terminal_writer_top #(
    .COLUMNS(COLS),
    .ROWS(ROWS_N),
    .TAB_WIDTH(TAB_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .char_in(char_bus),
    .cell_out(cell_bus)
  );

  always #4 clk = ~clk;

  // predictor state: cursor position on the screen
  logic [RowW-1:0] cur_row;
  logic [ColW-1:0] cur_col;

  cell_result_t cell_expect_q[$];
  char_row_t    pending_rows_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  int mismatches;
  int chars_taken;
  int cells_seen;
  int newlines;
  int tabs;
  int backspaces;
  int col0_backspaces;
  int row_wraps;

  // directed rows: extremes, every control character, row end and screen wrap
  char_row_t directed_rows [DIRECTED_N] = '{
    '{8'h41, 8'h00, 1'b1, '{1'b1, 11'd0, 16'h0041, 11'd1, 1'b1}},
    '{CH_BACKSPACE, 8'hFF, 1'b1, '{1'b1, 11'd0, 16'hFF20, 11'd0, 1'b1}},
    '{CH_BACKSPACE, 8'h00, 1'b1, '{1'b0, 11'd0, 16'h0000, 11'd1999, 1'b1}},
    '{8'hFF, 8'hFF, 1'b1, '{1'b1, 11'd1999, 16'hFFFF, 11'd0, 1'b1}},
    '{CH_BACKSPACE, 8'h11, 1'b0, '0},
    '{CH_TAB, 8'h42, 1'b1, '{1'b1, 11'd1999, 16'h4220, 11'd0, 1'b1}},
    '{CH_BACKSPACE, 8'h00, 1'b0, '0},
    '{CH_NEWLINE, 8'h5A, 1'b1, '{1'b0, 11'd0, 16'h0000, 11'd0, 1'b1}},
    '{8'h00, 8'hA5, 1'b1, '{1'b1, 11'd0, 16'hA500, 11'd1, 1'b1}},
    '{CH_TAB, 8'h17, 1'b0, '0},
    '{CH_NEWLINE, 8'h3C, 1'b0, '0},
    '{CH_BACKSPACE, 8'h81, 1'b0, '0},
    '{CH_BACKSPACE, 8'h7E, 1'b0, '0},
    '{CH_BACKSPACE, 8'h00, 1'b0, '0},
    '{CH_TAB, 8'h0F, 1'b0, '0},
    '{8'h07, 8'h33, 1'b0, '0},
    '{8'h0B, 8'h44, 1'b0, '0},
    '{CH_SPACE, 8'h70, 1'b0, '0},
    '{8'h80, 8'h01, 1'b0, '0},
    '{8'h7F, 8'h80, 1'b0, '0},
    '{CH_TAB, 8'hC3, 1'b0, '0},
    '{CH_NEWLINE, 8'h00, 1'b0, '0}
  };

  function automatic logic [AddrW-1:0] cell_index(input logic [RowW-1:0] r,
                                                  input logic [ColW-1:0] c);
    return AddrW'(int'(r) * COLS + int'(c));
  endfunction

  function automatic logic [RowW-1:0] row_below(input logic [RowW-1:0] r);
    return (int'(r) + 1 >= ROWS_N) ? '0 : r + 1'b1;
  endfunction

  // work out the cell writes of one character and move the cursor
  task automatic predict_char(input logic [7:0] ch, input logic [7:0] attr);
    cell_result_t res;
    int           start_col;
    int           tab_count;
    logic [RowW-1:0] start_row;
    logic [WordW-1:0] blank;
    blank = {attr, CH_SPACE};
    res   = '0;
    case (ch)
      CH_NEWLINE: begin
        newlines++;
        cur_col = '0;
        cur_row = row_below(cur_row);
        if (cur_row == 0) row_wraps++;
        res.cursor = cell_index(cur_row, cur_col);
        res.last   = 1'b1;
        cell_expect_q.push_back(res);
      end
      CH_TAB: begin
        tabs++;
        start_col = int'(cur_col);
        start_row = cur_row;
        tab_count = TAB_W;
        if (start_col + tab_count > COLS) tab_count = COLS - start_col;
        if (start_col + TAB_W >= COLS) begin
          cur_col = '0;
          cur_row = row_below(cur_row);
          if (cur_row == 0) row_wraps++;
        end else begin
          cur_col = ColW'(start_col + TAB_W);
        end
        for (int i = 0; i < tab_count; i++) begin
          res.wr     = 1'b1;
          res.addr   = cell_index(start_row, ColW'(start_col + i));
          res.word   = blank;
          res.last   = (i + 1 == tab_count);
          res.cursor = res.last ? cell_index(cur_row, cur_col) : '0;
          cell_expect_q.push_back(res);
        end
      end
      CH_BACKSPACE: begin
        backspaces++;
        if (cur_col == 0) begin
          col0_backspaces++;
          cur_col = ColW'(COLS - 1);
          cur_row = (cur_row == 0) ? RowW'(ROWS_N - 1) : cur_row - 1'b1;
        end else begin
          cur_col  = cur_col - 1'b1;
          res.wr   = 1'b1;
          res.addr = cell_index(cur_row, cur_col);
          res.word = blank;
        end
        res.cursor = cell_index(cur_row, cur_col);
        res.last   = 1'b1;
        cell_expect_q.push_back(res);
      end
      default: begin
        res.wr   = 1'b1;
        res.addr = cell_index(cur_row, cur_col);
        res.word = {attr, ch};
        if (int'(cur_col) + 1 >= COLS) begin
          cur_col = '0;
          cur_row = row_below(cur_row);
          if (cur_row == 0) row_wraps++;
        end else begin
          cur_col = cur_col + 1'b1;
        end
        res.cursor = cell_index(cur_row, cur_col);
        res.last   = 1'b1;
        cell_expect_q.push_back(res);
      end
    endcase
  endtask

  // present one word on char_in and hold it until it is taken
  task automatic send_char(input char_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= row.ch;
    char_bus.attribute <= row.attr;
    pending_rows_q.push_back(row);
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
  endtask

  // random character: mostly control codes and printables, any byte allowed
  function automatic char_row_t random_row();
    char_row_t row;
    int        pick;
    row      = '0;
    pick     = $urandom_range(99);
    row.attr = 8'($urandom_range(255));
    if (pick < 14)      row.ch = CH_NEWLINE;
    else if (pick < 28) row.ch = CH_TAB;
    else if (pick < 44) row.ch = CH_BACKSPACE;
    else                row.ch = 8'($urandom_range(255));
    return row;
  endfunction

  // receiver: random back-pressure on cell_out
  initial begin
    cell_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cell_bus.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on every accepted character, check every accepted cell word
  always @(posedge clk) begin : monitor
    char_row_t    row;
    cell_result_t got;
    cell_result_t want;
    logic         moved;
    if (!rst) begin
      moved = 1'b0;
      if (char_bus.valid && char_bus.ready) begin
        moved = 1'b1;
        chars_taken++;
        row = pending_rows_q.pop_front();
        predict_char(char_bus.char_code, char_bus.attribute);
        if (row.typed) begin
          void'(cell_expect_q.pop_back());
          cell_expect_q.push_back(row.exp);
        end
      end
      if (cell_bus.valid && cell_bus.ready) begin
        moved = 1'b1;
        cells_seen++;
        got = '{cell_bus.cell_write, cell_bus.cell_address, cell_bus.cell_word,
                cell_bus.cursor_position, cell_bus.last};
        if (cell_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected cell word wr=%0d addr=%0d word=%h cur=%0d last=%0d",
                     $realtime, got.wr, got.addr, got.word, got.cursor, got.last);
        end else begin
          want = cell_expect_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: cell word mismatch exp wr=%0d addr=%0d word=%h cur=%0d last=%0d, %s",
                       $realtime, want.wr, want.addr, want.word, want.cursor, want.last,
                       $sformatf("got wr=%0d addr=%0d word=%h cur=%0d last=%0d",
                                 got.wr, got.addr, got.word, got.cursor, got.last));
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog: no handshake on either side for too long
  initial begin
    quiet_cycles = 0;
    @(negedge rst);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d cell words still due",
             QUIET_LIMIT, cell_expect_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus: reset, directed rows, then three idling phases of random characters
  initial begin
    mismatches      = 0;
    chars_taken     = 0;
    cells_seen      = 0;
    newlines        = 0;
    tabs            = 0;
    backspaces      = 0;
    col0_backspaces = 0;
    row_wraps       = 0;
    cur_row         = '0;
    cur_col         = '0;
    send_idle_pct   = 37;
    recv_idle_pct   = 81;
    rst                <= 1'b1;
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= '0;
    char_bus.attribute <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_N; i++) send_char(directed_rows[i]);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_N / 3; i++) send_char(random_row());
    end
    char_bus.valid <= 1'b0;

    while (cell_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d characters (%0d newlines, %0d tabs, %0d backspaces), %0d cell words",
             chars_taken, newlines, tabs, backspaces, cells_seen);
    $display("cursor wrapped past the last row %0d times, backed over column 0 %0d times",
             row_wraps, col0_backspaces);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatching cell words", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tmtw_pkg.sv
hdl/tmtw_stream_if.sv
hdl/tmtw_cursor.sv
hdl/tmtw_sequencer.sv
hdl/text_mode_terminal_writer_top.sv
hdl/tmtw_checker.sv
sim/tb_text_mode_terminal_writer_top.sv
